// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int TAG_W   = 16;
    localparam int PRI_W   = 3;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CHANGE = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY,
        ST_INSERT
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // per-cell command: insert, shift and match enables
    typedef struct packed {
        logic ins;
        logic shift;
        logic match;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue: holds an entry, compares it against the broadcast
// item and moves data from or to its neighbors.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       occ,
    input  entry_t     new_entry,
    input  entry_t     prev_entry,
    input  logic       prev_keep,
    input  entry_t     next_entry,
    output entry_t     entry,
    output logic       keep,
    output logic       match
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   match_next;

    // an occupied slot of equal or higher priority stays ahead of a new item
    assign keep  = occ && (entry_reg.pri >= new_entry.pri);
    assign entry = entry_reg;
    assign match = match_reg;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        if (ctrl.ins && !keep)
        begin
            entry_next = prev_keep ? new_entry : prev_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = next_entry;
        end
        if (ctrl.match)
        begin
            match_next = occ && (entry_reg.tag == new_entry.tag);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

// ----- rtl/core/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue kept sorted in a row of cells, highest priority at cell 0.
// ----------------------------------------------------------------------------
// channel | dir | fields (lsb first)
// s_axis  | in  | cmd[1:0] tag[17:2] priority_req[20:18]
// m_axis  | out | status[1:0] out_tag[17:2] out_priority[20:18] count[25:21]
//
// one item at a time: insert and pop run ST_APPLY, delete runs the tag-match
// pass over the cells first, and change adds the remove-then-place pair to it.
// a finished result sits in the output register; the next item is accepted
// while it waits, and only the final step of that item stalls on m_tready.
// reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd, tag, priority_req
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, out_tag, out_priority, count
);

    localparam int CW = $clog2(DEPTH + 1);

    state_t           state_reg, state_next;
    cmd_t             cmd_reg;
    entry_t           req_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             mvalid_reg, mvalid_next;
    status_t          ostat_reg, ostat_next;
    entry_t           oent_reg, oent_next;
    logic [COUNT_W-1:0] ocount_reg;

    logic             accept;
    logic             out_free;
    logic             full;
    logic             empty;
    logic             found;
    logic             do_ins, do_shift, do_match, shift_all;
    entry_t           captured;

    entry_t           cell_entry [DEPTH];
    logic [DEPTH-1:0] keep_vec;
    logic [DEPTH-1:0] match_vec;
    logic [DEPTH-1:0] seen_vec;
    logic [DEPTH-1:0] first_hit;
    logic [DEPTH-1:0] occ_vec;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign found    = |match_vec;

    // ---------------- cell row ----------------
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_ctrl_t ctrl;
            entry_t     prev_e;
            entry_t     next_e;
            logic       prev_k;

            assign occ_vec[i]   = (CW'(i) < count_reg);
            assign seen_vec[i]  = |match_vec[i:0];
            assign ctrl.ins     = do_ins;
            assign ctrl.shift   = do_shift && (shift_all || seen_vec[i]);
            assign ctrl.match   = do_match;

            if (i == 0)
            begin : g_head
                assign prev_e       = req_reg;
                assign prev_k       = 1'b1;
                assign first_hit[i] = match_vec[i];
            end
            else
            begin : g_body
                assign prev_e       = cell_entry[i-1];
                assign prev_k       = keep_vec[i-1];
                assign first_hit[i] = match_vec[i] && !seen_vec[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign next_e = '0;
            end
            else
            begin : g_mid
                assign next_e = cell_entry[i+1];
            end

            spq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .occ        (occ_vec[i]),
                .new_entry  (req_reg),
                .prev_entry (prev_e),
                .prev_keep  (prev_k),
                .next_entry (next_e),
                .entry      (cell_entry[i]),
                .keep       (keep_vec[i]),
                .match      (match_vec[i])
            );
        end
    endgenerate

    // entry at the first matching cell
    always_comb
    begin
        captured = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (first_hit[k])
            begin
                captured = captured | cell_entry[k];
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd_t'(s_tdata[CMD_W-1:0]);
            req_reg.tag <= s_tdata[CMD_W +: TAG_W];
            req_reg.pri <= s_tdata[CMD_W+TAG_W +: PRI_W];
        end
        ostat_reg <= ostat_next;
        oent_reg  <= oent_next;
        // count held with the waiting result while the queue moves on
        if (out_free)
        begin
            ocount_reg <= COUNT_W'(count_next);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        mvalid_next = mvalid_reg && !m_tready;
        ostat_next  = ostat_reg;
        oent_next   = oent_reg;
        do_ins      = 1'b0;
        do_shift    = 1'b0;
        do_match    = 1'b0;
        shift_all   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(s_tdata[CMD_W-1:0]) == CMD_DELETE ||
                        cmd_t'(s_tdata[CMD_W-1:0]) == CMD_CHANGE)
                    begin
                        state_next = ST_MATCH;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
            end

            ST_MATCH:
            begin
                do_match   = 1'b1;
                state_next = ST_APPLY;
            end

            ST_APPLY:
            begin
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (out_free)
                        begin
                            mvalid_next = 1'b1;
                            state_next  = ST_IDLE;
                            if (full)
                            begin
                                ostat_next = STAT_FULL;
                                oent_next  = '0;
                            end
                            else
                            begin
                                do_ins     = 1'b1;
                                count_next = count_reg + 1'b1;
                                ostat_next = STAT_OK;
                                oent_next  = req_reg;
                            end
                        end
                    end

                    CMD_POP:
                    begin
                        if (out_free)
                        begin
                            mvalid_next = 1'b1;
                            state_next  = ST_IDLE;
                            if (empty)
                            begin
                                ostat_next = STAT_EMPTY;
                                oent_next  = '0;
                            end
                            else
                            begin
                                do_shift   = 1'b1;
                                shift_all  = 1'b1;
                                count_next = count_reg - 1'b1;
                                ostat_next = STAT_OK;
                                oent_next  = cell_entry[0];
                            end
                        end
                    end

                    CMD_DELETE:
                    begin
                        if (out_free)
                        begin
                            mvalid_next = 1'b1;
                            state_next  = ST_IDLE;
                            if (!found)
                            begin
                                ostat_next = STAT_NOT_FOUND;
                                oent_next  = '0;
                            end
                            else
                            begin
                                do_shift   = 1'b1;
                                count_next = count_reg - 1'b1;
                                ostat_next = STAT_OK;
                                oent_next  = captured;
                            end
                        end
                    end

                    CMD_CHANGE:
                    begin
                        if (found)
                        begin
                            // take the entry out now, place it again in ST_INSERT once the output is free
                            do_shift   = 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = ST_INSERT;
                        end
                        else if (out_free)
                        begin
                            mvalid_next = 1'b1;
                            state_next  = ST_IDLE;
                            ostat_next  = STAT_NOT_FOUND;
                            oent_next   = '0;
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_INSERT:
            begin
                if (out_free)
                begin
                    do_ins      = 1'b1;
                    count_next  = count_reg + 1'b1;
                    mvalid_next = 1'b1;
                    ostat_next  = STAT_OK;
                    oent_next   = req_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {
        {(OUT_W - STAT_W - TAG_W - PRI_W - COUNT_W){1'b0}},
        ocount_reg,
        oent_reg.pri,
        oent_reg.tag,
        ostat_reg
    };

endmodule

// ----- rtl/core/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [STAT_W-1:0]  o_stat;
    logic [TAG_W-1:0]   o_tag;
    logic [PRI_W-1:0]   o_pri;
    logic [COUNT_W-1:0] o_count;
    logic               in_seen;

    assign o_stat  = m_tdata[STAT_W-1:0];
    assign o_tag   = m_tdata[STAT_W +: TAG_W];
    assign o_pri   = m_tdata[STAT_W+TAG_W +: PRI_W];
    assign o_count = m_tdata[STAT_W+TAG_W+PRI_W +: COUNT_W];
    assign in_seen = |s_tdata;

    // result held while stalled
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // errors carry no entry
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_stat != STAT_OK |-> o_tag == '0 && o_pri == '0)
        else $error("error result carries an entry");

    // full flag only at full depth
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_stat == STAT_FULL |-> o_count == COUNT_W'(DEPTH))
        else $error("full status with wrong count");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (in_seen || !in_seen) |=> !s_tready)
        else $error("second item accepted back to back");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_priority_queue_unit. It opens with a short
// table of commands: empty, full, duplicate tags, ties and priority changes.
// A random stream of commands follows, biased in turn toward mixed traffic,
// filling and draining. Typed table rows are checked against their
// listed results, every other result against an in-bench model of the sorted queue.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 1700;
    localparam int STALL_LIMIT = 2000;
    localparam int CALM_FIRST  = 500;
    localparam int CALM_LAST   = 800;
    localparam int DRAIN_POINT = 1100;

    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
        logic [4:0]       count;
    } queue_result_t;

    typedef struct {
        cmd_t             cmd;
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
        bit               typed;
        queue_result_t    want;
    } command_row_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b1;
    logic [OUT_W-1:0] m_tdata;

    // model of the queue contents, slot 0 is the head
    logic [PRI_W-1:0] held_pri [DEPTH];
    logic [TAG_W-1:0] held_tag [DEPTH];
    int               held_count;

    queue_result_t expected_results[$];
    command_row_t  command_table[$];
    int            errors;
    int            quiet_cycles;
    bit            calm;
    queue_result_t got;
    queue_result_t want;

    sorted_priority_queue_unit #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // goes behind every entry of equal or higher priority
    function automatic void queue_place(input logic [TAG_W-1:0] t, input logic [PRI_W-1:0] p);
        int i;
        i = held_count;
        while (i > 0 && held_pri[i-1] < p)
        begin
            held_pri[i] = held_pri[i-1];
            held_tag[i] = held_tag[i-1];
            i--;
        end
        held_pri[i] = p;
        held_tag[i] = t;
        held_count++;
    endfunction

    function automatic void queue_drop(input int pos);
        for (int j = pos; j + 1 < held_count; j++)
        begin
            held_pri[j] = held_pri[j+1];
            held_tag[j] = held_tag[j+1];
        end
        held_count--;
    endfunction

    function automatic queue_result_t predict_command(input cmd_t c,
                                                      input logic [TAG_W-1:0] t,
                                                      input logic [PRI_W-1:0] p);
        queue_result_t r;
        int pos;
        r = '{status: STAT_OK, tag: '0, pri: '0, count: '0};
        pos = held_count;
        for (int i = held_count - 1; i >= 0; i--)
        begin
            if (held_tag[i] == t)
                pos = i;
        end
        case (c)
            CMD_INSERT:
            begin
                if (held_count >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    queue_place(t, p);
                    r.tag = t;
                    r.pri = p;
                end
            end
            CMD_POP:
            begin
                if (held_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.tag = held_tag[0];
                    r.pri = held_pri[0];
                    queue_drop(0);
                end
            end
            default:
            begin
                if (pos >= held_count)
                    r.status = STAT_NOT_FOUND;
                else if (c == CMD_DELETE)
                begin
                    r.tag = held_tag[pos];
                    r.pri = held_pri[pos];
                    queue_drop(pos);
                end
                else
                begin
                    // a change re-enters behind its new peers, even at the same priority
                    queue_drop(pos);
                    queue_place(t, p);
                    r.tag = t;
                    r.pri = p;
                end
            end
        endcase
        r.count = held_count[4:0];
        return r;
    endfunction

    task automatic add_row(input cmd_t c, input logic [TAG_W-1:0] t, input logic [PRI_W-1:0] p,
                           input bit typed, input status_t st, input logic [TAG_W-1:0] wt,
                           input logic [PRI_W-1:0] wp, input logic [4:0] wc);
        command_row_t row;
        row.cmd   = c;
        row.tag   = t;
        row.pri   = p;
        row.typed = typed;
        row.want  = '{status: st, tag: wt, pri: wp, count: wc};
        command_table.push_back(row);
    endtask

    // holds the item until accepted, then records what it must produce
    task automatic send_item(input command_row_t row);
        queue_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - CMD_W - TAG_W - PRI_W){1'b0}}, row.pri, row.tag, row.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_command(row.cmd, row.tag, row.pri);
        expected_results.push_back(row.typed ? row.want : r);
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic cmd_t pick_cmd(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       return cmd_t'(roll % 4);
            1:       return roll < 70 ? CMD_INSERT : cmd_t'(1 + roll % 3);
            default: return roll < 15 ? CMD_INSERT : roll < 70 ? CMD_POP : cmd_t'(2 + roll % 2);
        endcase
    endfunction

    function automatic command_row_t random_command(input int mode);
        command_row_t row;
        int roll;
        row.cmd   = pick_cmd(mode);
        row.typed = 1'b0;
        row.want  = '0;
        roll      = $urandom_range(0, 99);
        // small tag pool makes duplicates, live tags make delete and change hit
        if ((row.cmd == CMD_DELETE || row.cmd == CMD_CHANGE) && held_count > 0 && roll < 85)
            row.tag = held_tag[$urandom_range(0, held_count - 1)];
        else if (roll < 40)
            row.tag = TAG_W'($urandom_range(0, 7));
        else if (roll < 50)
            row.tag = roll[0] ? '1 : '0;
        else
            row.tag = TAG_W'($urandom);
        row.pri = $urandom_range(0, 1) ? PRI_W'($urandom_range(2, 3)) : PRI_W'($urandom_range(0, 7));
        return row;
    endfunction

    // result checking and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{status: status_t'(m_tdata[1:0]), tag: m_tdata[17:2],
                        pri: m_tdata[20:18], count: m_tdata[25:21]};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, got %p", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %s got %s", $time,
                                 want.status.name(), got.status.name());
                    end
                    if (got.tag != want.tag)
                    begin
                        errors++;
                        $display("%0t: out_tag expected %h got %h", $time, want.tag, got.tag);
                    end
                    if (got.pri != want.pri)
                    begin
                        errors++;
                        $display("%0t: out_priority expected %0d got %0d", $time,
                                 want.pri, got.pri);
                    end
                    if (got.count != want.count)
                    begin
                        errors++;
                        $display("%0t: count expected %0d got %0d", $time,
                                 want.count, got.count);
                    end
                end
            end
            m_tready <= calm || $urandom_range(0, 99) >= 15;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        errors       = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        held_count   = 0;

        add_row(CMD_POP,    16'h0000, 3'd0, 1'b1, STAT_EMPTY,     16'h0000, 3'd0, 5'd0);
        add_row(CMD_DELETE, 16'h1234, 3'd0, 1'b1, STAT_NOT_FOUND, 16'h0000, 3'd0, 5'd0);
        add_row(CMD_CHANGE, 16'h1234, 3'd5, 1'b1, STAT_NOT_FOUND, 16'h0000, 3'd0, 5'd0);
        add_row(CMD_INSERT, 16'h0000, 3'd0, 1'b1, STAT_OK,        16'h0000, 3'd0, 5'd1);
        add_row(CMD_INSERT, 16'hffff, 3'd7, 1'b1, STAT_OK,        16'hffff, 3'd7, 5'd2);
        add_row(CMD_INSERT, 16'h0055, 3'd3, 1'b0, STAT_OK, '0, '0, '0);
        add_row(CMD_INSERT, 16'h0055, 3'd3, 1'b0, STAT_OK, '0, '0, '0);
        add_row(CMD_INSERT, 16'h00aa, 3'd3, 1'b0, STAT_OK, '0, '0, '0);
        add_row(CMD_CHANGE, 16'h0055, 3'd3, 1'b0, STAT_OK, '0, '0, '0);
        add_row(CMD_DELETE, 16'h0055, 3'd0, 1'b0, STAT_OK, '0, '0, '0);
        add_row(CMD_CHANGE, 16'hffff, 3'd0, 1'b0, STAT_OK, '0, '0, '0);
        add_row(CMD_POP,    16'h0000, 3'd0, 1'b0, STAT_OK, '0, '0, '0);
        // three entries left, fill the rest
        for (int i = 0; i < DEPTH - 3; i++)
            add_row(CMD_INSERT, 16'h1000 + i[15:0], i[2:0], 1'b0, STAT_OK, '0, '0, '0);
        add_row(CMD_INSERT, 16'hdead, 3'd7, 1'b1, STAT_FULL,      16'h0000, 3'd0, 5'd16);
        add_row(CMD_POP,    16'h0000, 3'd0, 1'b0, STAT_OK, '0, '0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (command_table[i])
        begin
            send_item(command_table[i]);
            maybe_idle();
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            send_item(random_command((n / 80) % 3));
            if (n == DRAIN_POINT)
            begin
                s_tvalid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            else
                maybe_idle();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sorted_priority_queue_unit.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
rtl/core/spq_checker.sv
dv/testbench.sv
